// ===== sv/ssiq_pkg.sv =====
// Shared types and constants for the sorted set insert and query block.
package ssiq_pkg;

  localparam int unsigned DefCapacity   = 16;
  localparam int unsigned DefValueWidth = 32;
  localparam int unsigned CountOutWidth = 5;

  localparam logic OP_ADD = 1'b0;

  // Control bits of the operation wave that travels along the cell chain.
  typedef struct packed {
    logic act;    // a wave is present at this point of the chain
    logic add;    // the operation is an add
    logic full;   // the set was full when the operation entered
    logic found;  // an equal entry has been seen in a lower cell
    logic ins;    // insertion has started and entries are moving up
    logic cv;     // the displaced entry in the carry is a real entry
  } ssiq_ctl_t;

endpackage

// ===== sv/ssiq_cell.sv =====
// One cell of the sorted chain: holds one entry and processes the passing wave.
module ssiq_cell #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned IDX         = 0,
  localparam int unsigned CW         = $clog2(CAPACITY + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  ssiq_pkg::ssiq_ctl_t    ctl_i,
  input  logic [VALUE_WIDTH-1:0] key_i,
  input  logic [VALUE_WIDTH-1:0] carry_i,
  input  logic [CW-1:0]          cnt_i,
  output ssiq_pkg::ssiq_ctl_t    ctl_o,
  output logic [VALUE_WIDTH-1:0] key_o,
  output logic [VALUE_WIDTH-1:0] carry_o,
  output logic [CW-1:0]          cnt_o
);
  import ssiq_pkg::*;

  logic [VALUE_WIDTH-1:0] entry_q, entry_d;
  logic [VALUE_WIDTH-1:0] key_q, carry_q, carry_d;
  logic [CW-1:0]          cnt_q;
  ssiq_ctl_t              ctl_q, ctl_d;
  logic                   in_range, lt, eq;

  // Entries are held as order keys, so an unsigned compare gives signed order.
  assign in_range = CW'(IDX) < cnt_i;
  assign lt       = in_range && (entry_q < key_i);
  assign eq       = in_range && (entry_q == key_i);

  always_comb begin
    ctl_d   = ctl_i;
    carry_d = carry_i;
    entry_d = entry_q;
    if (ctl_i.act) begin
      if (ctl_i.ins) begin
        if (ctl_i.cv) begin
          entry_d = carry_i;
          carry_d = entry_q;
          ctl_d.cv = in_range;
        end
      end else if (eq) begin
        ctl_d.found = 1'b1;
      end else if (!lt && ctl_i.add && !ctl_i.full && !ctl_i.found) begin
        entry_d   = key_i;
        carry_d   = entry_q;
        ctl_d.ins = 1'b1;
        ctl_d.cv  = in_range;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      key_q   <= key_i;
      carry_q <= carry_d;
      cnt_q   <= cnt_i;
      if (ctl_i.act) begin
        entry_q <= entry_d;
      end
    end
  end

  assign ctl_o   = ctl_q;
  assign key_o   = key_q;
  assign carry_o = carry_q;
  assign cnt_o   = cnt_q;

endmodule

// ===== sv/sorted_set_insert_query.sv =====
// A word accepted at the port passes through every cell register of the chain and then into the result register.
// Only one word is in the chain at a time: the wave walks the cell chain one cell per
// cycle while the chain is not held, and a new word enters once the previous wave has left.
// The result register lets the next word enter while a result waits to be taken.
// Reset clears the entry count and all control state; entries hold no reset value.
module sorted_set_insert_query #(
  parameter int unsigned CAPACITY    = ssiq_pkg::DefCapacity,
  parameter int unsigned VALUE_WIDTH = ssiq_pkg::DefValueWidth
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    opcode_i,
  input  logic signed [VALUE_WIDTH-1:0]           value_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic                                    present_o,
  output logic                                    inserted_o,
  output logic                                    full_reject_o,
  output logic [ssiq_pkg::CountOutWidth-1:0]      entry_count_o
);
  import ssiq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Links between the cells; link 0 is fed from the input port.
  ssiq_ctl_t              ctl_l   [CAPACITY+1];
  logic [VALUE_WIDTH-1:0] key_l   [CAPACITY+1];
  logic [VALUE_WIDTH-1:0] carry_l [CAPACITY+1];
  logic [CW-1:0]          cnt_l   [CAPACITY+1];

  logic          busy_q, busy_d;
  logic          out_valid_q, out_valid_d;
  logic          present_q, inserted_q, full_q;
  logic [CW-1:0] count_q;
  logic          accept, adv, load;
  ssiq_ctl_t     last;

  // Only one word is in the chain at a time, so the port is free whenever no
  // wave is travelling.
  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;

  // The new word enters cell 0 directly.  The sign bit is flipped so that the
  // cells can order the values by an unsigned compare.  The full flag is
  // settled here from the count, which is stable while the wave travels.
  assign ctl_l[0]   = '{act:   accept,
                        add:   (opcode_i == OP_ADD),
                        full:  (count_q == CW'(CAPACITY)),
                        found: 1'b0,
                        ins:   1'b0,
                        cv:    1'b0};
  assign key_l[0]   = {~value_i[VALUE_WIDTH-1], value_i[VALUE_WIDTH-2:0]};
  assign carry_l[0] = '0;
  assign cnt_l[0]   = count_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ssiq_cell #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX         (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .ctl_i   (ctl_l[i]),
      .key_i   (key_l[i]),
      .carry_i (carry_l[i]),
      .cnt_i   (cnt_l[i]),
      .ctl_o   (ctl_l[i+1]),
      .key_o   (key_l[i+1]),
      .carry_o (carry_l[i+1]),
      .cnt_o   (cnt_l[i+1])
    );
  end

  assign last = ctl_l[CAPACITY];

  // The chain holds still when a finished wave cannot yet move into the
  // result register because the previous result has not been taken.
  assign load = last.act && (!out_valid_q || out_ready_i);
  assign adv  = !(last.act && !load);

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (load) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (load) begin
        count_q <= cnt_l[CAPACITY] + CW'(last.ins);
      end
    end
  end

  // An add of a new value into a full set is rejected; an add that finds the
  // value already held is not, even when the set is full.
  always_ff @(posedge clk_i) begin
    if (load) begin
      present_q  <= last.found;
      inserted_q <= last.ins;
      full_q     <= last.add && last.full && !last.found;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign present_o     = present_q;
  assign inserted_o    = inserted_q;
  assign full_reject_o = full_q;
  // The count only changes when a result is loaded, so it doubles as the
  // entry count of the result on display.
  assign entry_count_o = CountOutWidth'(count_q);

endmodule
